// File: rtl/core/pcr_pkg.sv
// ----------------------------------------------------------------------------
// Packet capture ring package
// Field widths, register map, result codes and the structs shared by the
// controller, datapath and top level.
// ----------------------------------------------------------------------------
package pcr_pkg;

    localparam int LEN_W   = 16;
    localparam int PORT_W  = 8;
    localparam int ORIG_W  = 2;
    localparam int IDX_W   = 32;
    localparam int STAMP_W = 32;
    localparam int CNT_W   = 7;
    localparam int BYTES_W = 22;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [0:0] REG_DROP_MODE = 1'b0;
    localparam logic [0:0] REG_CAPACITY  = 1'b1;

    localparam logic [CNT_W-1:0] CAPACITY_RESET = 7'd64;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    typedef enum logic [2:0] {
        ST_STORED    = 3'd0,
        ST_EVICTED   = 3'd1,
        ST_DROPPED   = 3'd2,
        ST_POPPED    = 3'd3,
        ST_UNDERFLOW = 3'd4,
        ST_NONE      = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_EVICT,
        FSM_POP
    } fsm_t;

    typedef struct packed {
        logic [LEN_W-1:0]   len;
        logic [PORT_W-1:0]  port;
        logic [ORIG_W-1:0]  origin;
        logic [IDX_W-1:0]   index;
        logic [STAMP_W-1:0] stamp;
    } rec_t;

    typedef struct packed {
        status_t             status;
        logic                rec_valid;
        rec_t                rec;
        logic                last;
        logic [CNT_W-1:0]    fill;
        logic [BYTES_W-1:0]  byte_total;
    } res_t;

    typedef struct packed {
        logic    take;
        logic    store_in;
        logic    evict_store;
        logic    rd_head;
        logic    rd_next;
        logic    pop_emit;
        logic    emit_plain;
        status_t code;
    } cmd_t;

    typedef struct packed {
        logic is_pop;
        logic full;
        logic drop_mode;
        logic pop_zero;
        logic pop_over;
        logic out_free;
        logic last_pop;
    } stat_t;

endpackage

// File: rtl/core/pcr_if.sv
// ----------------------------------------------------------------------------
// Packet capture ring channels
// Request channel (push or pop) and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pcr_req_if
    import pcr_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                action;
    logic [LEN_W-1:0]    pkt_len;
    logic [PORT_W-1:0]   port_num;
    logic [ORIG_W-1:0]   origin_kind;
    logic [IDX_W-1:0]    seq_index;
    logic [STAMP_W-1:0]  stamp;
    logic [CNT_W-1:0]    pop_count;

    modport source (
        output valid, action, pkt_len, port_num, origin_kind, seq_index, stamp,
               pop_count,
        input  ready
    );

    modport sink (
        input  valid, action, pkt_len, port_num, origin_kind, seq_index, stamp,
               pop_count,
        output ready
    );
endinterface

interface pcr_res_if
    import pcr_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [2:0]          status;
    logic                rec_valid;
    logic [LEN_W-1:0]    rec_len;
    logic [PORT_W-1:0]   rec_port;
    logic [ORIG_W-1:0]   rec_origin;
    logic [IDX_W-1:0]    rec_index;
    logic [STAMP_W-1:0]  rec_stamp;
    logic                last;
    logic [CNT_W-1:0]    fill;
    logic [BYTES_W-1:0]  byte_total;

    modport source (
        output valid, status, rec_valid, rec_len, rec_port, rec_origin, rec_index,
               rec_stamp, last, fill, byte_total,
        input  ready
    );

    modport sink (
        input  valid, status, rec_valid, rec_len, rec_port, rec_origin, rec_index,
               rec_stamp, last, fill, byte_total,
        output ready
    );
endinterface

// File: rtl/core/pcr_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/pcr_ctrl.sv
// ----------------------------------------------------------------------------
// Packet capture ring controller
// Sequences push, drop-head eviction and multi-record pop requests.
// ----------------------------------------------------------------------------
module pcr_ctrl
    import pcr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    fsm_t state_reg;
    fsm_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.code   = ST_STORED;
        in_ready   = 1'b0;
        unique case (state_reg)
            FSM_IDLE:
            begin
                in_ready = stat.out_free;
                if (in_valid && stat.out_free)
                begin
                    cmd.take = 1'b1;
                    if (!stat.is_pop)
                    begin
                        if (!stat.full)
                        begin
                            cmd.store_in   = 1'b1;
                            cmd.emit_plain = 1'b1;
                            cmd.code       = ST_STORED;
                        end
                        else if (stat.drop_mode)
                        begin
                            cmd.rd_head = 1'b1;
                            state_next  = FSM_EVICT;
                        end
                        else
                        begin
                            cmd.emit_plain = 1'b1;
                            cmd.code       = ST_DROPPED;
                        end
                    end
                    else if (stat.pop_zero)
                    begin
                        cmd.emit_plain = 1'b1;
                        cmd.code       = ST_NONE;
                    end
                    else if (stat.pop_over)
                    begin
                        cmd.emit_plain = 1'b1;
                        cmd.code       = ST_UNDERFLOW;
                    end
                    else
                    begin
                        cmd.rd_head = 1'b1;
                        state_next  = FSM_POP;
                    end
                end
            end
            FSM_EVICT:
            begin
                cmd.evict_store = 1'b1;
                cmd.emit_plain  = 1'b1;
                cmd.code        = ST_EVICTED;
                state_next      = FSM_IDLE;
            end
            FSM_POP:
            begin
                if (stat.out_free)
                begin
                    cmd.pop_emit = 1'b1;
                    if (stat.last_pop)
                    begin
                        state_next = FSM_IDLE;
                    end
                    else
                    begin
                        cmd.rd_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/pcr_dp.sv
// ----------------------------------------------------------------------------
// Packet capture ring datapath
// Descriptor store, ring pointers, fill and byte counters, register file and
// result register.
// ----------------------------------------------------------------------------
module pcr_dp
    import pcr_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    input  logic                in_action,
    input  rec_t                in_rec,
    input  logic [CNT_W-1:0]    in_pop_count,
    input  cmd_t                cmd,
    output stat_t               stat,
    output logic                out_valid,
    input  logic                out_ready,
    output res_t                out_res
);

    localparam int               PTR_W    = $clog2(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == LAST_PTR) ? '0 : p + 1'b1;
    endfunction

    logic                drop_mode_reg;
    logic [CNT_W-1:0]    capacity_reg;
    logic [PTR_W-1:0]    wptr_reg;
    logic [PTR_W-1:0]    wptr_next;
    logic [PTR_W-1:0]    rptr_reg;
    logic [PTR_W-1:0]    rptr_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [BYTES_W-1:0]  bytes_reg;
    logic [BYTES_W-1:0]  bytes_next;
    logic [CNT_W-1:0]    remain_reg;
    logic [CNT_W-1:0]    remain_next;
    rec_t                held_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    res_t                out_reg;
    res_t                out_next;

    logic [CNT_W-1:0]    limit;
    logic                cfg_wr;
    logic                wr_en;
    logic [PTR_W-1:0]    wr_addr;
    rec_t                wr_data;
    logic                rd_en;
    logic [PTR_W-1:0]    rd_addr;
    rec_t                rd_data;

    // Register file
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_mode_reg <= 1'b0;
            capacity_reg  <= CAPACITY_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2:2])
                REG_DROP_MODE: drop_mode_reg <= pwdata[0];
                REG_CAPACITY:  capacity_reg  <= pwdata[CNT_W-1:0];
                default:       drop_mode_reg <= drop_mode_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2:2])
            REG_DROP_MODE: prdata = {{(DATA_W-1){1'b0}}, drop_mode_reg};
            REG_CAPACITY:  prdata = {{(DATA_W-CNT_W){1'b0}}, capacity_reg};
            default:       prdata = '0;
        endcase
    end

    always_comb
    begin
        if (capacity_reg == '0)
        begin
            limit = CNT_W'(1);
        end
        else if (capacity_reg > DEPTH_C)
        begin
            limit = DEPTH_C;
        end
        else
        begin
            limit = capacity_reg;
        end
    end

    assign stat.is_pop    = (in_action == ACT_POP);
    assign stat.full      = (count_reg >= limit);
    assign stat.drop_mode = drop_mode_reg;
    assign stat.pop_zero  = (in_pop_count == '0);
    assign stat.pop_over  = (in_pop_count > count_reg);
    assign stat.out_free  = !out_valid_reg || out_ready;
    assign stat.last_pop  = (remain_reg == CNT_W'(1));

    pcr_ram #(
        .WIDTH ($bits(rec_t)),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        wptr_next      = wptr_reg;
        rptr_next      = rptr_reg;
        count_next     = count_reg;
        bytes_next     = bytes_reg;
        remain_next    = remain_reg;
        wr_en          = 1'b0;
        wr_addr        = wptr_reg;
        wr_data        = in_rec;
        rd_en          = cmd.rd_head || cmd.rd_next;
        rd_addr        = cmd.rd_next ? bump(rptr_reg) : rptr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;

        if (cmd.take && stat.is_pop)
        begin
            remain_next = in_pop_count;
        end

        if (cmd.store_in)
        begin
            wr_en      = 1'b1;
            wptr_next  = bump(wptr_reg);
            count_next = count_reg + 1'b1;
            bytes_next = bytes_reg + BYTES_W'(in_rec.len);
        end

        if (cmd.evict_store)
        begin
            wr_en      = 1'b1;
            wr_data    = held_reg;
            wptr_next  = bump(wptr_reg);
            rptr_next  = bump(rptr_reg);
            bytes_next = bytes_reg - BYTES_W'(rd_data.len) + BYTES_W'(held_reg.len);
        end

        if (cmd.pop_emit)
        begin
            rptr_next   = bump(rptr_reg);
            count_next  = count_reg - 1'b1;
            bytes_next  = bytes_reg - BYTES_W'(rd_data.len);
            remain_next = remain_reg - 1'b1;
        end

        if (cmd.emit_plain)
        begin
            out_valid_next      = 1'b1;
            out_next.status     = cmd.code;
            out_next.rec_valid  = 1'b0;
            out_next.rec        = '0;
            out_next.last       = 1'b1;
            out_next.fill       = count_next;
            out_next.byte_total = bytes_next;
        end
        else if (cmd.pop_emit)
        begin
            out_valid_next      = 1'b1;
            out_next.status     = ST_POPPED;
            out_next.rec_valid  = 1'b1;
            out_next.rec        = rd_data;
            out_next.last       = stat.last_pop;
            out_next.fill       = count_next;
            out_next.byte_total = bytes_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg      <= '0;
            rptr_reg      <= '0;
            count_reg     <= '0;
            bytes_reg     <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wptr_reg      <= wptr_next;
            rptr_reg      <= rptr_next;
            count_reg     <= count_next;
            bytes_reg     <= bytes_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (cmd.take)
        begin
            held_reg <= in_rec;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= DEPTH_C)
        else $error("fill count above ring depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_emit |-> (count_reg != '0) && (remain_reg != '0))
        else $error("pop from an empty ring");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.evict_store |-> $past(cmd.rd_head))
        else $error("eviction without a head read");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.rec_valid |-> out_reg.status == ST_POPPED)
        else $error("record carried on a non-pop result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_plain || cmd.pop_emit) |-> !out_valid_reg || out_ready)
        else $error("result register overwritten");
`endif

endmodule

// File: rtl/core/packet_capture_ring_unit.sv
// Results register as the request is taken, or in FSM_EVICT on an eviction.
// Push, drop-tail, underflow and empty pop complete without leaving FSM_IDLE.
// A drop-head eviction reads the head record first, then stores in FSM_EVICT.
// A pop of N emits one record a cycle from the store read port unless stalled.
// Reset: pointers, fill and byte total clear; drop_mode 0, capacity 64.
// The descriptor store is not cleared; an entry is only read after being written.
// ----------------------------------------------------------------------------
// Packet capture ring unit
// Ring of captured-packet descriptors with drop-tail or drop-head on full
// and multi-record pop, configured over an APB-style port.
// ----------------------------------------------------------------------------
module packet_capture_ring_unit
    import pcr_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    pcr_req_if.sink           req,
    pcr_res_if.source         rsp
);

    cmd_t  cmd;
    stat_t stat;
    rec_t  in_rec;
    res_t  res;
    logic  in_ready;

    assign pready = 1'b1;

    assign in_rec.len    = req.pkt_len;
    assign in_rec.port   = req.port_num;
    assign in_rec.origin = req.origin_kind;
    assign in_rec.index  = req.seq_index;
    assign in_rec.stamp  = req.stamp;
    assign req.ready     = in_ready;

    pcr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pcr_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .in_action    (req.action),
        .in_rec       (in_rec),
        .in_pop_count (req.pop_count),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (rsp.valid),
        .out_ready    (rsp.ready),
        .out_res      (res)
    );

    assign rsp.status     = res.status;
    assign rsp.rec_valid  = res.rec_valid;
    assign rsp.rec_len    = res.rec.len;
    assign rsp.rec_port   = res.rec.port;
    assign rsp.rec_origin = res.rec.origin;
    assign rsp.rec_index  = res.rec.index;
    assign rsp.rec_stamp  = res.rec.stamp;
    assign rsp.last       = res.last;
    assign rsp.fill       = res.fill;
    assign rsp.byte_total = res.byte_total;

endmodule

// File: bench/pcr_ring_checker.sv
// ----------------------------------------------------------------------------
// Packet capture ring checker
// Watches the configuration port and both channels, keeps its own copy of
// the ring and its settings, predicts the results of every accepted request
// and compares each accepted result, field by field, with the oldest one.
// ----------------------------------------------------------------------------
module pcr_ring_checker
    import pcr_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    pcr_req_if                req,
    pcr_res_if                rsp,
    output int                fail_count,
    output int                pending,
    output int                stored
);

    rec_t               ring_copy [DEPTH];
    int                 head_slot;
    int                 tail_slot;
    int                 fill_count;
    logic [BYTES_W-1:0] byte_sum;
    logic               evict_mode;
    logic [CNT_W-1:0]   cap_setting;
    res_t               expected_results [$];

    function automatic int next_slot(input int p);
        return (p == DEPTH - 1) ? 0 : p + 1;
    endfunction

    function automatic int ring_limit();
        if (cap_setting == 0)
        begin
            return 1;
        end
        if (cap_setting > DEPTH)
        begin
            return DEPTH;
        end
        return int'(cap_setting);
    endfunction

    task automatic post_result(input status_t st, input logic has_rec, input rec_t r,
                               input logic is_last);
        res_t e;
        e.status     = st;
        e.rec_valid  = has_rec;
        e.rec        = has_rec ? r : '0;
        e.last       = is_last;
        e.fill       = fill_count[CNT_W-1:0];
        e.byte_total = byte_sum;
        expected_results.push_back(e);
    endtask

    task automatic retire_head();
        byte_sum   = byte_sum - BYTES_W'(ring_copy[head_slot].len);
        head_slot  = next_slot(head_slot);
        fill_count = fill_count - 1;
    endtask

    task automatic predict_request(input logic act, input rec_t r,
                                   input logic [CNT_W-1:0] cnt);
        status_t st;
        rec_t    popped;
        int      n;
        n = int'(cnt);
        if (act == ACT_PUSH)
        begin
            st = ST_STORED;
            if (fill_count >= ring_limit())
            begin
                if (!evict_mode)
                begin
                    post_result(ST_DROPPED, 1'b0, '0, 1'b1);
                    return;
                end
                if (fill_count > 0)
                begin
                    retire_head();
                end
                st = ST_EVICTED;
            end
            ring_copy[tail_slot] = r;
            byte_sum   = byte_sum + BYTES_W'(r.len);
            tail_slot  = next_slot(tail_slot);
            fill_count = fill_count + 1;
            post_result(st, 1'b0, '0, 1'b1);
        end
        else if (n == 0)
        begin
            post_result(ST_NONE, 1'b0, '0, 1'b1);
        end
        else if (n > fill_count)
        begin
            post_result(ST_UNDERFLOW, 1'b0, '0, 1'b1);
        end
        else
        begin
            for (int k = 0; k < n; k++)
            begin
                popped = ring_copy[head_slot];
                retire_head();
                post_result(ST_POPPED, 1'b1, popped, k == n - 1);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t e;
        rec_t r;
        if (!rst_n)
        begin
            head_slot   = 0;
            tail_slot   = 0;
            fill_count  = 0;
            byte_sum    = '0;
            evict_mode  = 1'b0;
            cap_setting = CAPACITY_RESET;
            fail_count  = 0;
            expected_results.delete();
            pending    <= 0;
            stored     <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no request pending, status %0d", rsp.status);
                    fail_count++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    check_field("status", 32'(e.status), 32'(rsp.status));
                    check_field("rec_valid", 32'(e.rec_valid), 32'(rsp.rec_valid));
                    check_field("rec_len", 32'(e.rec.len), 32'(rsp.rec_len));
                    check_field("rec_port", 32'(e.rec.port), 32'(rsp.rec_port));
                    check_field("rec_origin", 32'(e.rec.origin), 32'(rsp.rec_origin));
                    check_field("rec_index", e.rec.index, rsp.rec_index);
                    check_field("rec_stamp", e.rec.stamp, rsp.rec_stamp);
                    check_field("last", 32'(e.last), 32'(rsp.last));
                    check_field("fill", 32'(e.fill), 32'(rsp.fill));
                    check_field("byte_total", 32'(e.byte_total), 32'(rsp.byte_total));
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == {REG_DROP_MODE, 2'b00})
                begin
                    evict_mode = pwdata[0];
                end
                else if (paddr == {REG_CAPACITY, 2'b00})
                begin
                    cap_setting = pwdata[CNT_W-1:0];
                end
            end
            if (req.valid && req.ready)
            begin
                r.len    = req.pkt_len;
                r.port   = req.port_num;
                r.origin = req.origin_kind;
                r.index  = req.seq_index;
                r.stamp  = req.stamp;
                predict_request(req.action, r, req.pop_count);
            end
            pending <= expected_results.size();
            stored  <= fill_count;
        end
    end

endmodule

// File: bench/packet_capture_ring_unit_tb.sv
// ----------------------------------------------------------------------------
// Packet capture ring unit testbench
// Drives push and pop requests and configuration writes into the ring, with
// random gaps on the request side and random stalls on the result side, and
// leaves prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module packet_capture_ring_unit_tb;
    import pcr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    int                fail_count;
    int                pending;
    int                stored;
    int                quiet_cycles;
    bit                idle_on;

    pcr_req_if req_ch ();
    pcr_res_if rsp_ch ();

    packet_capture_ring_unit #(
        .DEPTH(64)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .req    (req_ch),
        .rsp    (rsp_ch)
    );

    pcr_ring_checker #(
        .DEPTH(64)
    ) u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .pready    (pready),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .fail_count(fail_count),
        .pending   (pending),
        .stored    (stored)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL packet_capture_ring_unit");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (idle_on && $urandom_range(0, 4) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    function automatic rec_t random_record();
        rec_t r;
        int   pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
        begin
            r.len = '0;
        end
        else if (pick == 1)
        begin
            r.len = '1;
        end
        else
        begin
            r.len = LEN_W'($urandom);
        end
        r.port   = PORT_W'($urandom);
        r.origin = ORIG_W'($urandom);
        r.index  = ($urandom_range(0, 9) == 0) ? '1 : $urandom;
        r.stamp  = ($urandom_range(0, 9) == 0) ? '0 : $urandom;
        return r;
    endfunction

    task automatic send_request(input logic act, input rec_t r, input logic [CNT_W-1:0] cnt);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.action      <= act;
        req_ch.pkt_len     <= r.len;
        req_ch.port_num    <= r.port;
        req_ch.origin_kind <= r.origin;
        req_ch.seq_index   <= r.index;
        req_ch.stamp       <= r.stamp;
        req_ch.pop_count   <= cnt;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic quiesce();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic mode, input logic [CNT_W-1:0] cap);
        logic [DATA_W-1:0] word;
        quiesce();
        word    = $urandom;
        word[0] = mode;
        apb_write({REG_DROP_MODE, 2'b00}, word);
        word              = $urandom;
        word[CNT_W-1:0]   = cap;
        apb_write({REG_CAPACITY, 2'b00}, word);
    endtask

    task automatic random_phase(input logic mode, input logic [CNT_W-1:0] cap,
                                input int n_items, input int push_pct, input bit hold_mid);
        int roll;
        int room;
        int cnt;
        configure(mode, cap);
        for (int i = 0; i < n_items; i++)
        begin
            if (hold_mid && i == n_items / 2)
            begin
                quiesce();
            end
            roll = $urandom_range(0, 99);
            if (roll < 6)
            begin
                cnt = (roll < 2 || stored >= 64) ? 0 : $urandom_range(stored + 1, 64);
                send_request(ACT_POP, random_record(), CNT_W'(cnt));
            end
            else if (roll < 6 + push_pct)
            begin
                send_request(ACT_PUSH, random_record(), CNT_W'($urandom));
            end
            else
            begin
                room = (stored == 0) ? 1 : stored;
                cnt  = ($urandom_range(0, 3) == 0) ? room
                                                   : $urandom_range(1, room < 6 ? room : 6);
                send_request(ACT_POP, random_record(), CNT_W'(cnt));
            end
        end
    endtask

    initial
    begin
        idle_on            = 1'b1;
        rst_n              <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.action      <= ACT_PUSH;
        req_ch.pkt_len     <= '0;
        req_ch.port_num    <= '0;
        req_ch.origin_kind <= '0;
        req_ch.seq_index   <= '0;
        req_ch.stamp       <= '0;
        req_ch.pop_count   <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // drop-tail, small ring: empty pops, extremes, full ring
        configure(1'b0, 7'd4);
        send_request(ACT_POP, '0, 7'd0);
        send_request(ACT_POP, '0, 7'd1);
        send_request(ACT_POP, '1, 7'd64);
        send_request(ACT_PUSH, '1, '0);
        send_request(ACT_PUSH, '0, '1);
        send_request(ACT_PUSH, random_record(), '0);
        send_request(ACT_PUSH, random_record(), '0);
        send_request(ACT_PUSH, random_record(), '0);
        send_request(ACT_POP, random_record(), 7'd5);
        send_request(ACT_POP, random_record(), 7'd4);

        // drop-head eviction
        configure(1'b1, 7'd2);
        send_request(ACT_PUSH, random_record(), '0);
        send_request(ACT_PUSH, random_record(), '0);
        send_request(ACT_PUSH, random_record(), '0);
        send_request(ACT_POP, random_record(), 7'd2);

        // lower capacity below fill
        configure(1'b1, 7'd64);
        for (int i = 0; i < 5; i++)
        begin
            send_request(ACT_PUSH, random_record(), '0);
        end
        configure(1'b1, 7'd2);
        send_request(ACT_PUSH, random_record(), '0);
        send_request(ACT_POP, random_record(), 7'd5);

        // zero capacity behaves as one
        configure(1'b0, 7'd0);
        send_request(ACT_PUSH, random_record(), '0);
        send_request(ACT_PUSH, random_record(), '0);
        send_request(ACT_POP, random_record(), 7'd1);

        random_phase(1'b0, 7'd5, 45, 55, 1'b0);
        random_phase(1'b1, 7'd3, 45, 55, 1'b1);
        random_phase(1'b1, 7'd0, 30, 60, 1'b0);
        random_phase(1'b1, 7'd127, 80, 88, 1'b0);
        random_phase(1'b0, 7'd1, 30, 55, 1'b0);
        idle_on = 1'b0;
        random_phase(1'b0, 7'd64, 40, 55, 1'b0);

        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("PASS packet_capture_ring_unit");
        end
        else
        begin
            $display("FAIL packet_capture_ring_unit");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/pcr_pkg.sv
rtl/core/pcr_if.sv
rtl/core/pcr_ram.sv
rtl/core/pcr_ctrl.sv
rtl/core/pcr_dp.sv
rtl/core/packet_capture_ring_unit.sv
bench/pcr_ring_checker.sv
bench/packet_capture_ring_unit_tb.sv
